### design/sha1_message_digest_defines.svh
// assertion macros shared by the sha1 digest checker
// depends on nothing; expects clk and rst_n in the scope of use
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH

// condition holds in the same cycle
`define SMD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha1 digest check failed");

// condition holds in the next cycle
`define SMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha1 digest check failed");

`endif

### design/smd_pkg.sv
// shared types, constants and helpers for the sha1 digest block
// depends on nothing
package smd_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } result_t;

    // one 512-bit block handed from the front to the core
    typedef struct packed {
        logic [511:0] block;
        logic         last_block;
    } job_t;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_FIT_LIMIT = 6'd56;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [2:0] LAST_INDEX = 3'd4;

    function automatic logic [31:0] rotl1(input logic [31:0] x);
        rotl1 = {x[30:0], x[31]};
    endfunction

    function automatic logic [31:0] rotl5(input logic [31:0] x);
        rotl5 = {x[26:0], x[31:27]};
    endfunction

    function automatic logic [31:0] rotl30(input logic [31:0] x);
        rotl30 = {x[1:0], x[31:2]};
    endfunction

endpackage

### design/smd_front.sv
// front end: takes bytes, packs blocks, adds padding and length
// depends on smd_pkg
module smd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  smd_pkg::item_t item,
    output logic          job_valid,
    input  logic          job_ready,
    output smd_pkg::job_t job
);
    import smd_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_BYTE = 4'b0010,
        F_PAD  = 4'b0100,
        F_LEN  = 4'b1000
    } fstate_t;

    fstate_t      state_reg, state_next;
    logic [5:0]   pos_reg, pos_next;
    logic [60:0]  cnt_reg, cnt_next;
    logic [511:0] blk_reg, blk_next;
    item_t        item_reg, item_next;

    logic [511:0] blk_wr;
    logic [511:0] blk_pad;
    logic [63:0]  bit_len;

    assign full    = (state_reg != F_IDLE);
    assign bit_len = {cnt_reg, 3'b000};

    // byte insert and padded block
    always_comb
    begin
        blk_wr  = blk_reg;
        blk_pad = blk_reg;
        for (int k = 0; k < 64; k++)
        begin
            if (6'(k) == pos_reg)
            begin
                blk_wr[511 - 8 * k -: 8]  = item_reg.data_byte;
                blk_pad[511 - 8 * k -: 8] = PAD_BYTE;
            end
            else if (6'(k) > pos_reg)
            begin
                blk_pad[511 - 8 * k -: 8] = 8'h00;
            end
        end
    end

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        blk_next   = blk_reg;
        item_next  = item_reg;
        job_valid  = 1'b0;
        job        = '0;
        case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    item_next  = item;
                    state_next = F_BYTE;
                end
            end
            F_BYTE:
            begin
                if (item_reg.byte_valid)
                begin
                    if (pos_reg == 6'd63)
                    begin
                        job_valid      = 1'b1;
                        job.block      = blk_wr;
                        job.last_block = 1'b0;
                    end
                    if (pos_reg != 6'd63 || job_ready)
                    begin
                        blk_next   = blk_wr;
                        pos_next   = pos_reg + 6'd1;
                        cnt_next   = cnt_reg + 61'd1;
                        state_next = item_reg.end_of_message ? F_PAD : F_IDLE;
                    end
                end
                else
                begin
                    state_next = item_reg.end_of_message ? F_PAD : F_IDLE;
                end
            end
            F_PAD:
            begin
                job_valid = 1'b1;
                if (pos_reg < LEN_FIT_LIMIT)
                begin
                    job.block      = {blk_pad[511:64], bit_len};
                    job.last_block = 1'b1;
                    if (job_ready)
                    begin
                        pos_next   = '0;
                        cnt_next   = '0;
                        state_next = F_IDLE;
                    end
                end
                else
                begin
                    job.block      = blk_pad;
                    job.last_block = 1'b0;
                    if (job_ready)
                    begin
                        state_next = F_LEN;
                    end
                end
            end
            F_LEN:
            begin
                job_valid      = 1'b1;
                job.block      = {448'd0, bit_len};
                job.last_block = 1'b1;
                if (job_ready)
                begin
                    pos_next   = '0;
                    cnt_next   = '0;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            pos_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        item_reg <= item_next;
    end

endmodule

### design/smd_queue.sv
// short block queue between the front end and the compression core
// depends on smd_pkg
module smd_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          enq_valid,
    output logic          enq_ready,
    input  smd_pkg::job_t enq_job,
    output logic          deq_valid,
    input  logic          deq_pop,
    output smd_pkg::job_t deq_job
);
    import smd_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    job_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_enq, do_deq;

    assign enq_ready = (cnt_reg != CW'(DEPTH));
    assign deq_valid = (cnt_reg != '0);
    assign deq_job   = slot_reg[rd_ptr_reg];
    assign do_enq    = enq_valid && enq_ready;
    assign do_deq    = deq_pop && deq_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_enq)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_deq)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_enq && !do_deq)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_deq && !do_enq)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_enq)
        begin
            slot_reg[wr_ptr_reg] <= enq_job;
        end
    end

endmodule

### design/smd_core.sv
// compression core: 80 rounds per block, chaining words, digest word buffer
// depends on smd_pkg
module smd_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    output logic            job_pop,
    input  smd_pkg::job_t   job,
    output logic            empty,
    input  logic            pop,
    output smd_pkg::result_t result
);
    import smd_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE  = 3'b001,
        C_ROUND = 3'b010,
        C_FOLD  = 3'b100
    } cstate_t;

    cstate_t     state_reg, state_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic        last_reg, last_next;
    logic [31:0] chain_reg [5];
    logic [31:0] chain_next [5];
    logic [31:0] var_reg [5];
    logic [31:0] var_next [5];
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] dig_reg [5];
    logic [31:0] dig_next [5];
    logic        busy_reg, busy_next;
    logic [2:0]  idx_reg, idx_next;

    logic [31:0] f_val, k_val, t_val;
    logic [31:0] init_chain [5];

    assign init_chain[0] = H0;
    assign init_chain[1] = H1;
    assign init_chain[2] = H2;
    assign init_chain[3] = H3;
    assign init_chain[4] = H4;

    // round function and constant
    always_comb
    begin
        if (rnd_reg < 7'd20)
        begin
            f_val = (var_reg[1] & var_reg[2]) | (~var_reg[1] & var_reg[3]);
            k_val = K0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f_val = var_reg[1] ^ var_reg[2] ^ var_reg[3];
            k_val = K1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f_val = (var_reg[1] & var_reg[2]) | (var_reg[1] & var_reg[3])
                  | (var_reg[2] & var_reg[3]);
            k_val = K2;
        end
        else
        begin
            f_val = var_reg[1] ^ var_reg[2] ^ var_reg[3];
            k_val = K3;
        end
        t_val = rotl5(var_reg[0]) + f_val + var_reg[4] + k_val + w_reg[0];
    end

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        last_next  = last_reg;
        chain_next = chain_reg;
        var_next   = var_reg;
        w_next     = w_reg;
        dig_next   = dig_reg;
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        job_pop    = 1'b0;

        // digest word transfer
        if (busy_reg && pop)
        begin
            if (idx_reg == LAST_INDEX)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end

        case (state_reg)
            C_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop   = 1'b1;
                    last_next = job.last_block;
                    rnd_next  = '0;
                    var_next  = chain_reg;
                    for (int j = 0; j < 16; j++)
                    begin
                        w_next[j] = job.block[511 - 32 * j -: 32];
                    end
                    state_next = C_ROUND;
                end
            end
            C_ROUND:
            begin
                for (int j = 0; j < 15; j++)
                begin
                    w_next[j] = w_reg[j + 1];
                end
                w_next[15] = rotl1(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0]);
                var_next[0] = t_val;
                var_next[1] = var_reg[0];
                var_next[2] = rotl30(var_reg[1]);
                var_next[3] = var_reg[2];
                var_next[4] = var_reg[3];
                rnd_next    = rnd_reg + 7'd1;
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = C_FOLD;
                end
            end
            C_FOLD:
            begin
                if (!last_reg)
                begin
                    for (int i = 0; i < 5; i++)
                    begin
                        chain_next[i] = chain_reg[i] + var_reg[i];
                    end
                    state_next = C_IDLE;
                end
                else if (!busy_reg)
                begin
                    for (int i = 0; i < 5; i++)
                    begin
                        dig_next[i] = chain_reg[i] + var_reg[i];
                    end
                    chain_next = init_chain;
                    busy_next  = 1'b1;
                    idx_next   = '0;
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    // control registers and chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            rnd_reg   <= '0;
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            chain_reg <= '{H0, H1, H2, H3, H4};
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            chain_reg <= chain_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        var_reg  <= var_next;
        w_reg    <= w_next;
        dig_reg  <= dig_next;
    end

    // result port
    assign empty              = !busy_reg;
    assign result.digest_word = dig_reg[idx_reg];
    assign result.word_index  = idx_reg;
    assign result.last_word   = (idx_reg == LAST_INDEX);

endmodule

### design/sha1_message_digest.sv
// sha1 digest top level: front end, block queue, compression core
// the front end takes one item at a time: full stays high until that item is through;
// the core runs one round per cycle and takes no new block before the last is folded;
// digest words leave one per cycle while pop is held high
// reset: clears all control state and loads the sha1 initial chaining words
// depends on smd_pkg, smd_front, smd_queue, smd_core
module sha1_message_digest #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  smd_pkg::item_t   item,
    output logic             empty,
    input  logic             pop,
    output smd_pkg::result_t result
);
    import smd_pkg::*;

    logic job_in_valid, job_in_ready, job_out_valid, job_out_pop;
    job_t job_in, job_out;

    smd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .job_valid (job_in_valid),
        .job_ready (job_in_ready),
        .job       (job_in)
    );

    smd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .enq_valid (job_in_valid),
        .enq_ready (job_in_ready),
        .enq_job   (job_in),
        .deq_valid (job_out_valid),
        .deq_pop   (job_out_pop),
        .deq_job   (job_out)
    );

    smd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_out_valid),
        .job_pop   (job_out_pop),
        .job       (job_out),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

### design/sha1_message_digest_checker.sv
// port-level checks on the digest word stream of the sha1 digest block
// depends on smd_pkg and sha1_message_digest_defines.svh
`include "sha1_message_digest_defines.svh"

module sha1_message_digest_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             empty,
    input logic             pop,
    input smd_pkg::result_t result
);
    import smd_pkg::*;

    // a stalled word holds
    `SMD_ASSERT_NEXT(a_hold, !empty && !pop, !empty && result == $past(result))
    // last marker only on the final word
    `SMD_ASSERT_NOW(a_last, !empty, result.last_word == (result.word_index == LAST_INDEX))
    // words of one digest come back to back in order
    `SMD_ASSERT_NEXT(a_order, pop && !empty && !result.last_word,
        !empty && result.word_index == $past(result.word_index) + 3'd1)
    // the stream drains after the final word
    `SMD_ASSERT_NEXT(a_drain, pop && !empty && result.last_word, empty)
    // a digest starts with its top word
    `SMD_ASSERT_NOW(a_start, $fell(empty), result.word_index == 3'd0)

endmodule

bind sha1_message_digest sha1_message_digest_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

### tb/tb_sha1_message_digest.sv
`timescale 1ns / 100ps
// testbench for the byte-serial sha1 digest block
// depends on smd_pkg and sha1_message_digest; predicts digests with its own sha1 model
module tb_sha1_message_digest;
    import smd_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 400;

    // idling modes
    typedef enum logic [1:0] {MODE_FREE, MODE_SEND_IDLE, MODE_RECV_STALL, MODE_BOTH} idle_mode_t;

    logic    clk;
    logic    rst_n;
    logic    push;
    logic    full;
    item_t   item;
    logic    empty;
    logic    pop;
    result_t result;

    sha1_message_digest u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // predictor state
    logic [31:0]  hash_chain [5];
    logic [31:0]  msg_block [16];
    logic [5:0]   fill_pos;
    logic [63:0]  bit_total;
    result_t      digest_queue [$];
    int           error_count;
    int           cycle_count;
    int           send_idle_pct;
    int           recv_stall_pct;

    function automatic logic [31:0] rot(input logic [31:0] x, input int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    // one sha1 compression over msg_block
    task automatic compress_msg_block();
        logic [31:0] sched [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 80; i++)
        begin
            if (i < 16)
                sched[i] = msg_block[i];
            else
                sched[i] = rot(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
        end
        a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2];
        d = hash_chain[3]; e = hash_chain[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d); k = K0;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d; k = K1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d); k = K2;
            end
            else
            begin
                f = b ^ c ^ d; k = K3;
            end
            t = rot(a, 5) + f + e + k + sched[i];
            e = d; d = c; c = rot(b, 30); b = a; a = t;
        end
        hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c;
        hash_chain[3] += d; hash_chain[4] += e;
    endtask

    task automatic place_byte(input int pos, input logic [7:0] val);
        msg_block[pos / 4][(3 - pos % 4) * 8 +: 8] = val;
    endtask

    task automatic restart_digest();
        hash_chain[0] = H0; hash_chain[1] = H1; hash_chain[2] = H2;
        hash_chain[3] = H3; hash_chain[4] = H4;
        fill_pos = '0;
        bit_total = '0;
    endtask

    // advance the predictor by one accepted item
    task automatic predict_item(input item_t it);
        result_t r;
        int      pos;
        if (it.byte_valid)
        begin
            place_byte(int'(fill_pos), it.data_byte);
            bit_total += 64'd8;
            fill_pos++;
            if (fill_pos == 0)
                compress_msg_block();
        end
        if (it.end_of_message)
        begin
            pos = int'(fill_pos);
            place_byte(pos, PAD_BYTE);
            for (int p = pos + 1; p < 64; p++)
                place_byte(p, 8'h00);
            if (pos >= LEN_FIT_LIMIT)
            begin
                compress_msg_block();
                for (int i = 0; i < 16; i++)
                    msg_block[i] = '0;
            end
            msg_block[14] = bit_total[63:32];
            msg_block[15] = bit_total[31:0];
            compress_msg_block();
            for (int i = 0; i < 5; i++)
            begin
                r.digest_word = hash_chain[i];
                r.word_index  = 3'(i);
                r.last_word   = (3'(i) == LAST_INDEX);
                digest_queue.push_back(r);
            end
            restart_digest();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // result side: pop and compare each transfer
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (pop && !empty)
            begin
                if (digest_queue.size() == 0)
                    report_mismatch("unexpected word", result.digest_word, '0);
                else
                begin
                    want = digest_queue.pop_front();
                    if (result.digest_word !== want.digest_word)
                        report_mismatch("digest_word", result.digest_word, want.digest_word);
                    if (result.word_index !== want.word_index)
                        report_mismatch("word_index", 32'(result.word_index),
                                        32'(want.word_index));
                    if (result.last_word !== want.last_word)
                        report_mismatch("last_word", 32'(result.last_word),
                                        32'(want.last_word));
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout");
                $display("tb_sha1_message_digest failed");
                $finish;
            end
        end
    end

    // drive one item, holding push until the transfer
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_item(it);
    endtask

    function automatic item_t make_item(input logic [7:0] b, input logic v, input logic e);
        item_t it;
        it.data_byte = b; it.byte_valid = v; it.end_of_message = e;
        return it;
    endfunction

    // directed rows: first digest word of "abc" and of the empty string read off directly
    typedef struct {
        item_t       it;
        logic        has_known;
        logic [31:0] known0;
    } stim_row_t;

    stim_row_t directed_rows [$];
    int        sent_items;

    task automatic send_message(input int len, input logic bare_end);
        for (int i = 0; i < len; i++)
        begin
            send_item(make_item(8'($urandom_range(255)), 1'b1,
                                (!bare_end && i == len - 1)));
            sent_items++;
        end
        if (bare_end || len == 0)
        begin
            send_item(make_item(8'($urandom_range(255)), 1'b0, 1'b1));
            sent_items++;
        end
    endtask

    initial
    begin
        idle_mode_t mode;
        int         len;
        error_count = 0;
        cycle_count = 0;
        sent_items = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        item = '0;
        restart_digest();
        for (int i = 0; i < 16; i++)
            msg_block[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, "abc", idle item, byte with end, extremes
        directed_rows.push_back('{make_item(8'h00, 1'b0, 1'b1), 1'b1, 32'hda39a3ee});
        directed_rows.push_back('{make_item(8'h61, 1'b1, 1'b0), 1'b0, '0});
        directed_rows.push_back('{make_item(8'h00, 1'b0, 1'b0), 1'b0, '0});
        directed_rows.push_back('{make_item(8'h62, 1'b1, 1'b0), 1'b0, '0});
        directed_rows.push_back('{make_item(8'h63, 1'b1, 1'b1), 1'b1, 32'ha9993e36});
        directed_rows.push_back('{make_item(8'hff, 1'b1, 1'b0), 1'b0, '0});
        directed_rows.push_back('{make_item(8'h00, 1'b1, 1'b0), 1'b0, '0});
        directed_rows.push_back('{make_item(8'hff, 1'b0, 1'b1), 1'b0, '0});
        directed_rows.push_back('{make_item(8'hff, 1'b1, 1'b1), 1'b0, '0});
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].has_known && directed_rows[i].it.end_of_message)
            begin
                // first digest word typed in; predictor covers the rest
                send_item(directed_rows[i].it);
                if (digest_queue[digest_queue.size() - 5].digest_word !==
                    directed_rows[i].known0)
                    report_mismatch("known digest", digest_queue[digest_queue.size() - 5]
                                    .digest_word, directed_rows[i].known0);
            end
            else
                send_item(directed_rows[i].it);
            sent_items++;
        end

        // pause until everything is drained
        push <= 1'b0;
        while (digest_queue.size() != 0)
            @(posedge clk);

        // padding boundaries: 55, 56, 63, 64 bytes
        send_message(55, 1'b0);
        send_message(56, 1'b0);
        send_message(63, 1'b1);
        send_message(64, 1'b0);

        // random messages across idling phases
        while (sent_items < 380)
        begin
            mode = idle_mode_t'($urandom_range(3));
            send_idle_pct  = (mode == MODE_SEND_IDLE || mode == MODE_BOTH) ?
                             ((mode == MODE_BOTH) ? 12 : 76) : 0;
            recv_stall_pct = (mode == MODE_RECV_STALL || mode == MODE_BOTH) ?
                             ((mode == MODE_BOTH) ? 12 : 76) : 0;
            repeat ($urandom_range(1, 4))
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 12);
                // some noise: an idle item before a message
                if ($urandom_range(3) == 0)
                    send_item(make_item(8'($urandom_range(255)), 1'b0, 1'b0));
                send_message(len, 1'($urandom_range(1)));
            end
        end

        // wait for the last digests
        push <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (digest_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && digest_queue.size() == 0)
            $display("tb_sha1_message_digest passed");
        else
            $display("tb_sha1_message_digest failed");
        $finish;
    end

endmodule
